@@ rtl/mpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared codes of the multilevel priority queue: operations and status.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

   localparam int VALUE_W  = 32;
   localparam int LEVEL_W  = 3;
   localparam int STATUS_W = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

endpackage

`default_nettype wire

@@ rtl/mpq_ram.sv @@
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-write, single-read memory with a registered read port.
// Read data holds its last value while rd_en is low.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/multilevel_priority_queue.sv @@
// ----------------------------------------------------------------------------
// multilevel_priority_queue
// Priority queue made of one circular FIFO per level, all held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation: insert req_value at req_level, or delete the
//   oldest item of the lowest-numbered non-empty level. Every request gives
//   exactly one response on rsp_*: status, removed value and its level.
//   Both channels transfer when valid and ready are high at a clock edge.
// Response path:
//   an insert or an underflowing delete loads the response register at its
//   transfer, and a new request can follow while that register is free or
//   leaving on rsp_ready. A delete that finds an item first reads the shared
//   RAM into its registered read port (S_READ), then loads the response; the
//   block takes no new request until it is back in S_IDLE.
// Stalls:
//   the response register holds until rsp_ready; a new request is taken in
//   the same cycle the waiting response leaves, never while it is stuck.
// Reset:
//   synchronous, clears all head, tail and count state so every level is
//   empty. The RAM itself is not cleared and needs no pass.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_priority_queue
   import mpq_pkg::*;
#(
   parameter int LEVELS = 8,
   parameter int DEPTH  = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_opcode,
   input  wire logic [LEVEL_W-1:0]  req_level,
   input  wire logic [VALUE_W-1:0]  req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [VALUE_W-1:0]       rsp_out_value,
   output logic [LEVEL_W-1:0]       rsp_out_level
);

   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = LVL_W + PTR_W;
   localparam int RAM_D  = LEVELS << PTR_W;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type              state_ff;
   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [VALUE_W-1:0]     rsp_value_ff;
   logic [LEVEL_W-1:0]     rsp_level_ff;
   logic [LEVEL_W-1:0]     pend_level_ff;

   logic [PTR_W-1:0]       head_ff  [LEVELS];
   logic [PTR_W-1:0]       tail_ff  [LEVELS];
   logic [CNT_W-1:0]       count_ff [LEVELS];

   logic                   xfer_in;
   logic                   is_insert;
   logic                   in_range;
   logic [LVL_W-1:0]       ins_idx;
   logic                   ins_ok;
   logic [LEVELS-1:0]      nonempty;
   logic                   any_nonempty;
   logic [LVL_W-1:0]       sel_idx;
   logic                   del_ok;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [VALUE_W-1:0]     rd_data;

   assign xfer_in   = req_valid && req_ready;
   assign is_insert = (req_opcode == OP_INSERT);
   assign in_range  = (32'(req_level) < 32'(LEVELS));
   assign ins_idx   = LVL_W'(req_level);
   assign ins_ok    = in_range && (count_ff[ins_idx] != CNT_W'(DEPTH));

   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         nonempty[i] = (count_ff[i] != '0);
      end
   end

   // lowest-numbered non-empty level wins
   always_comb begin
      sel_idx = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            sel_idx = LVL_W'(i);
         end
      end
   end

   assign any_nonempty = |nonempty;
   assign del_ok       = any_nonempty;

   // accept only when idle and the response register is free by this edge
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);

   assign wr_addr = {ins_idx, tail_ff[ins_idx]};
   assign rd_addr = {sel_idx, head_ff[sel_idx]};

   mpq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (RAM_D)
   ) u_store (
      .clock   (clock),
      .wr_en   (xfer_in && is_insert && ins_ok),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (xfer_in && !is_insert && del_ok),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // per-level pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (xfer_in) begin
         if (is_insert) begin
            if (ins_ok) begin
               tail_ff[ins_idx]  <= (tail_ff[ins_idx] == PTR_W'(DEPTH - 1)) ?
                                    '0 : tail_ff[ins_idx] + 1'b1;
               count_ff[ins_idx] <= count_ff[ins_idx] + 1'b1;
            end
         end else if (del_ok) begin
            head_ff[sel_idx]  <= (head_ff[sel_idx] == PTR_W'(DEPTH - 1)) ?
                                 '0 : head_ff[sel_idx] + 1'b1;
            count_ff[sel_idx] <= count_ff[sel_idx] - 1'b1;
         end
      end
   end

   // control and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (xfer_in) begin
                  if (is_insert) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= ins_ok ? ST_OK : ST_OVERFLOW;
                     rsp_value_ff  <= '0;
                     rsp_level_ff  <= '0;
                  end else if (del_ok) begin
                     pend_level_ff <= LEVEL_W'(sel_idx);
                     state_ff      <= S_READ;
                  end else begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= ST_UNDERFLOW;
                     rsp_value_ff  <= '0;
                     rsp_level_ff  <= '0;
                  end
               end
            end
            S_READ: begin
               // response register was freed when the delete transferred
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= ST_OK;
               rsp_value_ff  <= rd_data;
               rsp_level_ff  <= pend_level_ff;
               state_ff      <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_level = rsp_level_ff;

   // a successful delete always goes through the read state
   a_delete_reads: assert property (@(posedge clock) disable iff (reset)
      (xfer_in && !is_insert && any_nonempty) |=> (state_ff == S_READ))
      else $error("delete with data did not enter read state");

   // the read state always produces a response next
   a_read_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (rsp_valid_ff && (rsp_status_ff == ST_OK)))
      else $error("read state did not load a response");

   // no new request while a delete is still in flight
   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !req_ready)
      else $error("request accepted during ram read");

   // the response register is never overwritten while it is stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (xfer_in && rsp_valid_ff) |-> rsp_ready)
      else $error("request accepted while response stalled");

endmodule

`default_nettype wire

@@ dv/multilevel_priority_queue_test.sv @@
// ----------------------------------------------------------------------------
// multilevel_priority_queue_test
// Self-checking bench for the multilevel priority queue. Inserts and deletes
// are driven with random gaps against a random response stall, each accepted
// request updates a local model of the level FIFOs, and every response is
// compared field by field with the oldest predicted outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_priority_queue_test;
   import mpq_pkg::*;

   localparam int LEVELS = 8;
   localparam int DEPTH  = 16;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] value;
      logic [LEVEL_W-1:0] level;
   } queue_outcome_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_opcode = OP_INSERT;
   logic [LEVEL_W-1:0]  req_level = '0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_out_value;
   logic [LEVEL_W-1:0]  rsp_out_level;

   multilevel_priority_queue #(
      .LEVELS(LEVELS),
      .DEPTH (DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_level    (req_level),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_out_value(rsp_out_value),
      .rsp_out_level(rsp_out_level)
   );

   // local copy of the level FIFOs
   logic [VALUE_W-1:0] slot_mem [LEVELS*DEPTH];
   int unsigned        head_slot [LEVELS];
   int unsigned        tail_slot [LEVELS];
   int unsigned        fill_count [LEVELS];

   queue_outcome_type  expected_outcomes [$];
   int unsigned        mismatches = 0;
   bit                 no_gaps = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[multilevel_priority_queue] ERROR");
      $finish;
   end

   function automatic queue_outcome_type apply_queue_op(opcode_type op,
                                                        logic [LEVEL_W-1:0] lvl,
                                                        logic [VALUE_W-1:0] val);
      queue_outcome_type res;
      int                sel;
      res = '{status: ST_OK, value: '0, level: '0};
      if (op == OP_INSERT) begin
         if (int'(lvl) >= LEVELS || fill_count[lvl] >= DEPTH) begin
            res.status = ST_OVERFLOW;
         end else begin
            slot_mem[int'(lvl)*DEPTH + tail_slot[lvl]] = val;
            tail_slot[lvl] = (tail_slot[lvl] + 1) % DEPTH;
            fill_count[lvl]++;
         end
      end else begin
         // lowest-numbered non-empty level wins
         sel = -1;
         for (int i = LEVELS-1; i >= 0; i--) begin
            if (fill_count[i] != 0) sel = i;
         end
         if (sel < 0) begin
            res.status = ST_UNDERFLOW;
         end else begin
            res.value = slot_mem[sel*DEPTH + head_slot[sel]];
            res.level = LEVEL_W'(sel);
            head_slot[sel] = (head_slot[sel] + 1) % DEPTH;
            fill_count[sel]--;
         end
      end
      return res;
   endfunction

   // responses are checked before the request of the same edge is modeled
   always @(posedge clock) begin
      queue_outcome_type want;
      if (reset) begin
         foreach (head_slot[i]) begin
            head_slot[i]  = 0;
            tail_slot[i]  = 0;
            fill_count[i] = 0;
         end
         expected_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: status %0d value %h level %0d",
                           rsp_status, rsp_out_value, rsp_out_level);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_status !== want.status || rsp_out_value !== want.value ||
                   rsp_out_level !== want.level) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected status %0d value %h level %0d,",
                               " got status %0d value %h level %0d"},
                              want.status, want.value, want.level,
                              rsp_status, rsp_out_value, rsp_out_level);
               end
            end
         end
         if (req_valid && req_ready)
            expected_outcomes.push_back(apply_queue_op(opcode_type'(req_opcode),
                                                       req_level, req_value));
      end
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // response side stall pattern
   initial begin
      int unsigned run;
      int unsigned gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         rsp_ready = 1'b1;
         run = $urandom_range(1, 16);
         repeat (run) @(negedge clock);
         gap = idle_len();
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // holds the request until the transfer happens
   task automatic send_op(opcode_type op, logic [LEVEL_W-1:0] lvl,
                          logic [VALUE_W-1:0] val);
      int unsigned gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  = 1'b1;
      req_opcode = op;
      req_level  = lvl;
      req_value  = val;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic test_empty_delete();
      send_op(OP_DELETE, '1, 32'hDEAD_BEEF);
   endtask

   task automatic test_priority_order();
      send_op(OP_INSERT, 3'd7, 32'h7FFF_FFFF);
      send_op(OP_INSERT, 3'd0, 32'h8000_0000);
      send_op(OP_INSERT, 3'd0, 32'hFFFF_FFFF);
      repeat (3) send_op(OP_DELETE, LEVEL_W'($urandom), $urandom);
      send_op(OP_DELETE, '0, '0);
   endtask

   // fills one level so the tail wraps, then one more insert overflows
   task automatic test_level_overflow();
      for (int i = 0; i < DEPTH; i++)
         send_op(OP_INSERT, 3'd5, pick_value());
      send_op(OP_INSERT, 3'd5, 32'h1234_5678);
   endtask

   task automatic test_random_traffic(int unsigned total);
      int unsigned        sent;
      int unsigned        phase_len;
      int unsigned        insert_pct;
      int unsigned        focus_a;
      int unsigned        focus_b;
      bit                 focused;
      logic [LEVEL_W-1:0] lvl;
      sent = 0;
      while (sent < total) begin
         phase_len = $urandom_range(40, 160);
         case ($urandom_range(0, 3))
            0:       insert_pct = 85;
            1:       insert_pct = 20;
            default: insert_pct = 55;
         endcase
         // few target levels push them to full, delete-heavy phases drain to empty
         focused = ($urandom_range(0, 1) == 1);
         focus_a = $urandom_range(0, LEVELS-1);
         focus_b = $urandom_range(0, LEVELS-1);
         no_gaps = ($urandom_range(0, 4) == 0);
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < insert_pct) begin
               if (focused)
                  lvl = LEVEL_W'($urandom_range(0, 1) ? focus_a : focus_b);
               else
                  lvl = LEVEL_W'($urandom);
               send_op(OP_INSERT, lvl, pick_value());
            end else begin
               send_op(OP_DELETE, LEVEL_W'($urandom), $urandom);
            end
         end
         sent += phase_len;
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_delete();
      test_priority_order();
      test_level_overflow();
      test_random_traffic(1625);

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("[multilevel_priority_queue] OK");
      else
         $display("[multilevel_priority_queue] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
